>>> rtl/thcd_pkg.sv
`timescale 1ns / 1ps

package thcd_pkg;

  localparam int unsigned MINUTE_TICKS_W  = 27;
  localparam int unsigned LOCKOUT_TICKS_W = 24;
  localparam int unsigned SCAN_TICKS_W    = 20;
  localparam int unsigned ADDR_W          = 4;
  localparam int unsigned DATA_W          = 32;

  localparam logic [MINUTE_TICKS_W-1:0]  MINUTE_TICKS_RST  = 27'd60000000;
  localparam logic [LOCKOUT_TICKS_W-1:0] LOCKOUT_TICKS_RST = 24'd200000;
  localparam logic [SCAN_TICKS_W-1:0]    SCAN_TICKS_RST    = 20'd2500;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_MINUTE_TICKS  = 2'd0;
  localparam logic [1:0] REG_LOCKOUT_TICKS = 2'd1;
  localparam logic [1:0] REG_SCAN_TICKS    = 2'd2;

  // Digit positions on the display.
  localparam logic [1:0] DIGIT_HR_TENS  = 2'd0;
  localparam logic [1:0] DIGIT_HR_ONES  = 2'd1;
  localparam logic [1:0] DIGIT_MIN_TENS = 2'd2;
  localparam logic [1:0] DIGIT_MIN_ONES = 2'd3;

  localparam logic [7:0] DP_BIT = 8'b1000_0000;

  // Hex seven-segment patterns, bit 0 is segment A.
  localparam logic [7:0] SEG_TABLE [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h67, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };

  typedef struct packed {
    logic [MINUTE_TICKS_W-1:0]  minute_ticks;
    logic [LOCKOUT_TICKS_W-1:0] lockout_ticks;
    logic [SCAN_TICKS_W-1:0]    scan_ticks;
  } thcd_cfg_t;

  typedef struct packed {
    logic       hr_tens;
    logic [3:0] hr_ones;
    logic [2:0] min_tens;
    logic [3:0] min_ones;
  } thcd_time_t;

  typedef struct packed {
    logic       hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic [7:0] segments;
    logic [1:0] digit_select;
  } thcd_result_t;

  // One hour forward; thirteen o'clock becomes one o'clock.
  function automatic thcd_time_t add_hour(input thcd_time_t t);
    thcd_time_t r;
    r = t;
    r.hr_ones = r.hr_ones + 4'd1;
    if (r.hr_ones >= 4'd10) begin
      r.hr_ones = 4'd0;
      r.hr_tens = ~r.hr_tens;
    end
    if (r.hr_tens && (r.hr_ones == 4'd3)) begin
      r.hr_tens = 1'b0;
      r.hr_ones = 4'd1;
    end
    return r;
  endfunction

  // One minute forward with carries into the hour.
  function automatic thcd_time_t add_minute(input thcd_time_t t);
    thcd_time_t r;
    r = t;
    r.min_ones = r.min_ones + 4'd1;
    if (r.min_ones >= 4'd10) begin
      r.min_ones = 4'd0;
      r.min_tens = r.min_tens + 3'd1;
      if (r.min_tens >= 3'd6) begin
        r.min_tens = 3'd0;
        r = add_hour(r);
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/thcd_regs.sv
`timescale 1ns / 1ps

module thcd_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [thcd_pkg::ADDR_W-1:0]   paddr,
  input  logic [thcd_pkg::DATA_W-1:0]   pwdata,
  output logic [thcd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output thcd_pkg::thcd_cfg_t           cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.minute_ticks  <= thcd_pkg::MINUTE_TICKS_RST;
      cfg.lockout_ticks <= thcd_pkg::LOCKOUT_TICKS_RST;
      cfg.scan_ticks    <= thcd_pkg::SCAN_TICKS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        thcd_pkg::REG_MINUTE_TICKS: begin
          cfg.minute_ticks <= pwdata[thcd_pkg::MINUTE_TICKS_W-1:0];
        end
        thcd_pkg::REG_LOCKOUT_TICKS: begin
          cfg.lockout_ticks <= pwdata[thcd_pkg::LOCKOUT_TICKS_W-1:0];
        end
        thcd_pkg::REG_SCAN_TICKS: begin
          cfg.scan_ticks <= pwdata[thcd_pkg::SCAN_TICKS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      thcd_pkg::REG_MINUTE_TICKS: begin
        prdata = {{(thcd_pkg::DATA_W-thcd_pkg::MINUTE_TICKS_W){1'b0}}, cfg.minute_ticks};
      end
      thcd_pkg::REG_LOCKOUT_TICKS: begin
        prdata = {{(thcd_pkg::DATA_W-thcd_pkg::LOCKOUT_TICKS_W){1'b0}}, cfg.lockout_ticks};
      end
      thcd_pkg::REG_SCAN_TICKS: begin
        prdata = {{(thcd_pkg::DATA_W-thcd_pkg::SCAN_TICKS_W){1'b0}}, cfg.scan_ticks};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

>>> rtl/thcd_core.sv
`timescale 1ns / 1ps

module thcd_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   minute_button_n,
  input  logic                   hour_button_n,
  input  thcd_pkg::thcd_cfg_t    cfg,
  output thcd_pkg::thcd_result_t result_next
);

  logic [thcd_pkg::MINUTE_TICKS_W-1:0]  minute_elapsed, minute_elapsed_next, minute_inc;
  logic [thcd_pkg::LOCKOUT_TICKS_W-1:0] lockout_elapsed, lockout_elapsed_next, lockout_run;
  logic [thcd_pkg::SCAN_TICKS_W-1:0]    scan_elapsed, scan_elapsed_next, scan_inc;
  logic [1:0]                           scan_digit, scan_digit_next;
  thcd_pkg::thcd_time_t                 time_q, time_timer, time_next;
  logic                                 minute_fire, press, press_taken, scan_fire;
  logic [3:0]                           shown;

  always_comb begin
    // Minute timer comes first within a tick.
    minute_inc          = minute_elapsed + 1'b1;
    minute_fire         = minute_inc >= cfg.minute_ticks;
    minute_elapsed_next = minute_fire ? '0 : minute_inc;
    time_timer          = minute_fire ? thcd_pkg::add_minute(time_q) : time_q;

    // The lockout counter parks once it reaches its limit.
    lockout_run = (lockout_elapsed < cfg.lockout_ticks) ? lockout_elapsed + 1'b1
                                                        : lockout_elapsed;
    press       = !minute_button_n || !hour_button_n;
    press_taken = press && (lockout_run >= cfg.lockout_ticks);
    lockout_elapsed_next = press_taken ? '0 : lockout_run;
    if (!press_taken) begin
      time_next = time_timer;
    end else if (!minute_button_n) begin
      time_next = thcd_pkg::add_minute(time_timer);
    end else begin
      time_next = thcd_pkg::add_hour(time_timer);
    end

    scan_inc          = scan_elapsed + 1'b1;
    scan_fire         = scan_inc >= cfg.scan_ticks;
    scan_elapsed_next = scan_fire ? '0 : scan_inc;
    scan_digit_next   = scan_fire ? scan_digit + 2'd1 : scan_digit;

    case (scan_digit_next)
      thcd_pkg::DIGIT_MIN_ONES: shown = time_next.min_ones;
      thcd_pkg::DIGIT_MIN_TENS: shown = {1'b0, time_next.min_tens};
      thcd_pkg::DIGIT_HR_ONES:  shown = time_next.hr_ones;
      default:                  shown = {3'b000, time_next.hr_tens};
    endcase

    result_next.digit_select = scan_digit_next;
    result_next.segments     = thcd_pkg::SEG_TABLE[shown] |
        ((scan_digit_next == thcd_pkg::DIGIT_HR_ONES) ? thcd_pkg::DP_BIT : 8'h00);
    result_next.minute_ones  = time_next.min_ones;
    result_next.minute_tens  = time_next.min_tens;
    result_next.hour_ones    = time_next.hr_ones;
    result_next.hour_tens    = time_next.hr_tens;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      minute_elapsed  <= '0;
      lockout_elapsed <= '0;
      scan_elapsed    <= '0;
      scan_digit      <= '0;
      time_q          <= '0;
    end else if (step) begin
      minute_elapsed  <= minute_elapsed_next;
      lockout_elapsed <= lockout_elapsed_next;
      scan_elapsed    <= scan_elapsed_next;
      scan_digit      <= scan_digit_next;
      time_q          <= time_next;
    end
  end

endmodule

>>> rtl/twelve_hour_clock_display.sv
`timescale 1ns / 1ps

// Twelve-hour BCD clock with a four-digit multiplexed seven-segment display.
// Every word taken on the slave stream is one timer tick carrying the two
// active-low set-button levels; every tick yields exactly one word on the
// master stream with the digit being scanned, its segment pattern (decimal
// point lit on the hour-ones digit) and the four time digits after this
// tick's minute timer, button press and carries. Time starts at 00:00 and
// the hour reads 00 until it first advances, then runs 01 through 12.
// The block takes one word per clock while the master stream does not stall;
// a word goes through an input register and the state update into the output
// register, which offers its result word on the master stream, and one
// result can wait in the output register while the next tick is already held.
// The three tick counts are set over the APB port at 0x0 (minute_ticks),
// 0x4 (lockout_ticks) and 0x8 (scan_ticks); change them only while no tick
// is in flight.

module twelve_hour_clock_display (
  input  logic                        clk,
  input  logic                        rst,
  // Tick stream in.
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,  // [0] minute_button_n, [1] hour_button_n
  // Result stream out.
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [23:0]                 m_tdata,  // [1:0] digit_select, [9:2] segments,
                                                // [13:10] minute_ones, [16:14] minute_tens,
                                                // [20:17] hour_ones, [21] hour_tens
  // Configuration.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [thcd_pkg::ADDR_W-1:0] paddr,
  input  logic [thcd_pkg::DATA_W-1:0] pwdata,
  output logic [thcd_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  thcd_pkg::thcd_cfg_t    cfg;
  thcd_pkg::thcd_result_t result_next;
  thcd_pkg::thcd_result_t out_data;

  logic in_valid;
  logic in_minute_n;
  logic in_hour_n;
  logic out_valid;
  logic out_free;
  logic step;

  thcd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid || m_tready;
  // A held tick updates the clock state exactly when its result is stored.
  assign step     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_minute_n <= s_tdata[0];
      in_hour_n   <= s_tdata[1];
    end
  end

  thcd_core u_core (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .minute_button_n (in_minute_n),
    .hour_button_n   (in_hour_n),
    .cfg             (cfg),
    .result_next     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_data};

endmodule

>>> rtl/thcd_checker.sv
`timescale 1ns / 1ps

module thcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // Shown time is always a legal twelve-hour BCD time.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[13:10] <= 4'd9) && (m_tdata[16:14] <= 3'd5) &&
                 (m_tdata[20:17] <= 4'd9) && (!m_tdata[21] || (m_tdata[20:17] <= 4'd2)))
    else $error("time digits out of range");

  // Decimal point is lit exactly on the hour-ones digit.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[9] == (m_tdata[1:0] == 2'd1)))
    else $error("decimal point on wrong digit");

  // Padding bits stay zero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[23:22] == 2'b00))
    else $error("result padding not zero");

endmodule

bind twelve_hour_clock_display thcd_checker u_thcd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
